[rtl/rtt_stat_pkg.sv]
// rtt_stat_pkg: widths, request codes and sequencer states for the
// round-trip statistics accumulator and its checker. No dependencies.
package rtt_stat_pkg;

   localparam int RTT_BITS   = 16;
   localparam int COUNT_BITS = 20;
   localparam int LOSS_BITS  = 7;
   localparam int SUM_BITS   = RTT_BITS + COUNT_BITS;
   localparam int SQ_BITS    = 2 * RTT_BITS + COUNT_BITS;
   localparam int DIV_BITS   = SQ_BITS;
   localparam int STEP_BITS  = $clog2(DIV_BITS);

   localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
   localparam logic [LOSS_BITS-1:0]  PERCENT_MAX = LOSS_BITS'(100);

   localparam logic [1:0] REQ_SENT   = 2'd0;
   localparam logic [1:0] REQ_REPLY  = 2'd1;
   localparam logic [1:0] REQ_REPORT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_LOSS_DIV,
      ST_AVG_DIV,
      ST_MSQ_DIV,
      ST_AVG_MUL,
      ST_VAR,
      ST_SQRT,
      ST_PUBLISH
   } state_type;

endpackage

[rtl/rtt_statistics_accumulator.sv]
// rtt_statistics_accumulator: probe and reply counters, min/max/sum/square sum,
// and a report path built on a shared bit-serial divider, multiplier and root.
// Depends on rtt_stat_pkg.
// Sent request: counted when taken, next request accepted on the following cycle.
// Reply request: handled by the 16-step shift-add squarer plus accumulate.
// Report request: answered through the restoring divider (52 steps per divide,
// up to three divides) plus 16-step multiply and 16-step root.
// Synchronous active-high reset clears the counters, min/max/sum/square sum and the response valid flag.
module rtt_statistics_accumulator
   import rtt_stat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [RTT_BITS-1:0]   req_rtt_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_BITS-1:0] rsp_sent_total,
   output logic [COUNT_BITS-1:0] rsp_received_total,
   output logic [LOSS_BITS-1:0]  rsp_loss_percent,
   output logic                  rsp_has_replies,
   output logic [RTT_BITS-1:0]   rsp_min_ms,
   output logic [RTT_BITS-1:0]   rsp_avg_ms,
   output logic [RTT_BITS-1:0]   rsp_max_ms,
   output logic [RTT_BITS-1:0]   rsp_mdev_ms
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] sent_ff, reply_ff;
   logic [RTT_BITS-1:0]   min_ff, max_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SQ_BITS-1:0]    sqsum_ff;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   logic [COUNT_BITS-1:0] div_rem_ff;
   logic [DIV_BITS-1:0]   div_quo_ff;
   logic [RTT_BITS-1:0]   mul_hi_ff, mul_lo_ff, mul_cand_ff;
   logic [LOSS_BITS-1:0]  loss_ff;
   logic [RTT_BITS-1:0]   avg_ff;
   logic [2*RTT_BITS-1:0] msq_ff;
   logic [2*RTT_BITS-1:0] sq_rad_ff;
   logic [RTT_BITS:0]     sq_rem_ff;
   logic [RTT_BITS-1:0]   sq_root_ff;

   logic                  rsp_valid_ff;
   logic [COUNT_BITS-1:0] rsp_sent_ff, rsp_recv_ff;
   logic [LOSS_BITS-1:0]  rsp_loss_ff;
   logic                  rsp_has_ff;
   logic [RTT_BITS-1:0]   rsp_min_ff, rsp_avg_ff, rsp_max_ff, rsp_mdev_ff;

   logic                  req_take, step_last, rsp_free, entering, has_replies;
   logic [RTT_BITS-1:0]   rtt;
   logic [COUNT_BITS-1:0] half, lost;
   logic [DIV_BITS-1:0]   lost_x, loss_dividend, avg_dividend, msq_dividend, dividend;
   logic [COUNT_BITS-1:0] div_den, div_rem_next;
   logic [COUNT_BITS:0]   div_trial, div_diff;
   logic                  div_ge;
   logic [DIV_BITS-1:0]   div_quo_next;
   logic [RTT_BITS:0]     mul_sum;
   logic [2*RTT_BITS-1:0] product, variance;
   logic [RTT_BITS+2:0]   sq_rem_t, sq_trial, sq_diff;
   logic                  sq_ge;

   // handshake and shared terms
   always_comb begin
      req_take    = req_valid && !req_stall;
      step_last   = (step_ff == '0);
      rsp_free    = !rsp_valid_ff || !rsp_stall;
      entering    = (state_in != state_ff);
      has_replies = (reply_ff != '0);
      rtt         = req_rtt_ms[RTT_BITS-1:0];
      half        = {1'b0, reply_ff[COUNT_BITS-1:1]};
      lost        = (sent_ff > reply_ff) ? (sent_ff - reply_ff) : '0;
      lost_x      = DIV_BITS'(lost);
      // lost * 100 as three shifted terms
      loss_dividend = (lost_x << 6) + (lost_x << 5) + (lost_x << 2);
      avg_dividend  = DIV_BITS'(sum_ff) + DIV_BITS'(half);
      msq_dividend  = DIV_BITS'(sqsum_ff) + DIV_BITS'(half);
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      div_den      = (state_ff == ST_LOSS_DIV) ? sent_ff : reply_ff;
      div_trial    = {div_rem_ff, div_quo_ff[DIV_BITS-1]};
      div_diff     = div_trial - {1'b0, div_den};
      div_ge       = (div_trial >= {1'b0, div_den});
      div_rem_next = div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
      div_quo_next = {div_quo_ff[DIV_BITS-2:0], div_ge};
      case (state_in)
         ST_LOSS_DIV: dividend = loss_dividend;
         ST_AVG_DIV:  dividend = avg_dividend;
         default:     dividend = msq_dividend;
      endcase
   end

   // shift-add multiplier and bit-pair square root
   always_comb begin
      mul_sum  = {1'b0, mul_hi_ff} + {1'b0, (mul_lo_ff[0] ? mul_cand_ff : '0)};
      product  = {mul_hi_ff, mul_lo_ff};
      variance = (msq_ff > product) ? (msq_ff - product) : '0;
      sq_rem_t = {sq_rem_ff, sq_rad_ff[2*RTT_BITS-1 -: 2]};
      sq_trial = {1'b0, sq_root_ff, 2'b01};
      sq_diff  = sq_rem_t - sq_trial;
      sq_ge    = (sq_rem_t >= sq_trial);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_type)
                  REQ_REPLY: begin
                     if (reply_ff != CNT_MAX) state_in = ST_SQUARE;
                  end
                  REQ_REPORT: begin
                     if (sent_ff != '0)   state_in = ST_LOSS_DIV;
                     else if (has_replies) state_in = ST_AVG_DIV;
                     else                  state_in = ST_PUBLISH;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQUARE:   if (step_last) state_in = ST_ACCUM;
         ST_ACCUM:    state_in = ST_IDLE;
         ST_LOSS_DIV: begin
            if (step_last) state_in = has_replies ? ST_AVG_DIV : ST_PUBLISH;
         end
         ST_AVG_DIV:  if (step_last) state_in = ST_MSQ_DIV;
         ST_MSQ_DIV:  if (step_last) state_in = ST_AVG_MUL;
         ST_AVG_MUL:  if (step_last) state_in = ST_VAR;
         ST_VAR:      state_in = ST_SQRT;
         ST_SQRT:     if (step_last) state_in = ST_PUBLISH;
         ST_PUBLISH:  if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and step count
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = rsp_valid_ff;
      if (entering) begin
         case (state_in)
            ST_SQUARE, ST_AVG_MUL, ST_SQRT:        step_in = STEP_BITS'(RTT_BITS - 1);
            ST_LOSS_DIV, ST_AVG_DIV, ST_MSQ_DIV:   step_in = STEP_BITS'(DIV_BITS - 1);
            default:                               step_in = '0;
         endcase
      end else begin
         step_in = step_ff - 1'b1;
      end
   end

   assign rsp_sent_total     = rsp_sent_ff;
   assign rsp_received_total = rsp_recv_ff;
   assign rsp_loss_percent   = rsp_loss_ff;
   assign rsp_has_replies    = rsp_has_ff;
   assign rsp_min_ms         = rsp_min_ff;
   assign rsp_avg_ms         = rsp_avg_ff;
   assign rsp_max_ms         = rsp_max_ff;
   assign rsp_mdev_ms        = rsp_mdev_ff;

   // control and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sent_ff      <= '0;
         reply_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (state_ff == ST_IDLE && req_take) begin
            case (req_type)
               REQ_SENT: begin
                  if (sent_ff != CNT_MAX) sent_ff <= sent_ff + 1'b1;
               end
               REQ_REPLY: begin
                  if (reply_ff != CNT_MAX) begin
                     if (!has_replies || rtt < min_ff) min_ff <= rtt;
                     if (!has_replies || rtt > max_ff) max_ff <= rtt;
                     sum_ff   <= sum_ff + SUM_BITS'(rtt);
                     reply_ff <= reply_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_ACCUM) sqsum_ff <= sqsum_ff + SQ_BITS'(product);
         if (state_ff == ST_PUBLISH && rsp_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                    rsp_valid_ff <= 1'b0;
      end
   end

   // serial datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take && req_type == REQ_REPORT) loss_ff <= '0;

      if (entering && (state_in == ST_LOSS_DIV || state_in == ST_AVG_DIV ||
                       state_in == ST_MSQ_DIV)) begin
         div_rem_ff <= '0;
         div_quo_ff <= dividend;
      end else if (state_ff == ST_LOSS_DIV || state_ff == ST_AVG_DIV ||
                   state_ff == ST_MSQ_DIV) begin
         div_rem_ff <= div_rem_next;
         div_quo_ff <= div_quo_next;
      end
      if (step_last) begin
         case (state_ff)
            ST_LOSS_DIV: loss_ff <= div_quo_next[LOSS_BITS-1:0];
            ST_AVG_DIV:  avg_ff  <= div_quo_next[RTT_BITS-1:0];
            ST_MSQ_DIV:  msq_ff  <= div_quo_next[2*RTT_BITS-1:0];
            default: ;
         endcase
      end

      if (entering && state_in == ST_SQUARE) begin
         mul_hi_ff   <= '0;
         mul_lo_ff   <= rtt;
         mul_cand_ff <= rtt;
      end else if (entering && state_in == ST_AVG_MUL) begin
         mul_hi_ff   <= '0;
         mul_lo_ff   <= avg_ff;
         mul_cand_ff <= avg_ff;
      end else if (state_ff == ST_SQUARE || state_ff == ST_AVG_MUL) begin
         mul_hi_ff <= mul_sum[RTT_BITS:1];
         mul_lo_ff <= {mul_sum[0], mul_lo_ff[RTT_BITS-1:1]};
      end

      if (state_ff == ST_VAR) begin
         sq_rad_ff  <= variance;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (state_ff == ST_SQRT) begin
         sq_rad_ff  <= {sq_rad_ff[2*RTT_BITS-3:0], 2'b00};
         sq_rem_ff  <= sq_ge ? sq_diff[RTT_BITS:0] : sq_rem_t[RTT_BITS:0];
         sq_root_ff <= {sq_root_ff[RTT_BITS-2:0], sq_ge};
      end

      if (state_ff == ST_PUBLISH && rsp_free) begin
         rsp_sent_ff <= sent_ff;
         rsp_recv_ff <= reply_ff;
         rsp_loss_ff <= loss_ff;
         rsp_has_ff  <= has_replies;
         rsp_min_ff  <= has_replies ? min_ff : '0;
         rsp_avg_ff  <= has_replies ? avg_ff : '0;
         rsp_max_ff  <= has_replies ? max_ff : '0;
         rsp_mdev_ff <= has_replies ? sq_root_ff : '0;
      end
   end

endmodule

[rtl/rtt_stat_checker.sv]
// rtt_stat_checker: port-level assertions for the round-trip statistics
// accumulator, bound to the top level. Depends on rtt_stat_pkg.
module rtt_stat_checker
   import rtt_stat_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [1:0]            req_type,
   input logic [RTT_BITS-1:0]   req_rtt_ms,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COUNT_BITS-1:0] rsp_sent_total,
   input logic [COUNT_BITS-1:0] rsp_received_total,
   input logic [LOSS_BITS-1:0]  rsp_loss_percent,
   input logic                  rsp_has_replies,
   input logic [RTT_BITS-1:0]   rsp_min_ms,
   input logic [RTT_BITS-1:0]   rsp_avg_ms,
   input logic [RTT_BITS-1:0]   rsp_max_ms,
   input logic [RTT_BITS-1:0]   rsp_mdev_ms
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mdev_ms) && $stable(rsp_avg_ms))
      else $error("stalled response dropped or changed");

   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_loss_percent <= PERCENT_MAX)
      else $error("loss percent above 100");

   a_has_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_replies == (rsp_received_total != '0)))
      else $error("reply flag disagrees with reply count");

   a_empty_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_replies |->
         rsp_min_ms == '0 && rsp_avg_ms == '0 && rsp_max_ms == '0 && rsp_mdev_ms == '0)
      else $error("timing fields set without replies");

   a_avg_between: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_replies |-> rsp_min_ms <= rsp_avg_ms && rsp_avg_ms <= rsp_max_ms)
      else $error("average outside min and max");

endmodule

bind rtt_statistics_accumulator rtt_stat_checker u_rtt_stat_checker (.*);
